// ===== rtl/rbsi_pkg.sv =====
// rbsi_pkg: shared constants, face codes and control structs for the ray/box slab intersector
// no dependencies
`default_nettype none

package rbsi_pkg;

	// coordinate format
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS       = 16;

	// epsilon register
	localparam int                   EPS_WIDTH = 16;
	localparam logic [EPS_WIDTH-1:0] EPS_RESET = 16'd1;

	// face codes
	typedef logic [2:0] face_t;
	localparam face_t FACE_PX = 3'd0;
	localparam face_t FACE_NX = 3'd1;
	localparam face_t FACE_PY = 3'd2;
	localparam face_t FACE_NY = 3'd3;
	localparam face_t FACE_PZ = 3'd4;
	localparam face_t FACE_NZ = 3'd5;

	// face on the plus and minus side of each axis
	localparam face_t FACE_PLUS  [3] = '{FACE_PX, FACE_PY, FACE_PZ};
	localparam face_t FACE_MINUS [3] = '{FACE_NX, FACE_NY, FACE_NZ};

	// per-item slab flags traveling beside the dividers
	typedef struct packed {
		logic       valid;
		logic       rej;
		logic [2:0] dzero;
		logic [2:0] dpos;
		logic [5:0] neg;
	} slab_ctl_t;

	// item control after entry/exit selection
	typedef struct packed {
		logic  valid;
		logic  hit;
		face_t face;
	} ctl_t;

endpackage

`default_nettype wire

// ===== rtl/rbsi_div.sv =====
// rbsi_div: pipelined restoring divider, one quotient bit per stage
// depends on nothing; QW pipeline stages, one item per cycle
`default_nettype none

module rbsi_div #(
	parameter int W  = 32,
	parameter int QW = 49
) (
	input  logic          clk,
	input  logic [QW-1:0] dividend,
	input  logic [W-1:0]  divisor,
	output logic [QW-1:0] quotient
);

	// remainder in the top W bits, dividend shifting out / quotient shifting in below
	logic [W+QW-1:0] rq_s [QW];
	logic [W-1:0]    dv_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [W+QW-1:0] rq_in;
		logic [W-1:0]    dv_in;
		logic [W:0]      top;
		logic [W:0]      diff;
		logic            ge;

		if (i == 0) begin : g_first
			assign rq_in = {{W{1'b0}}, dividend};
			assign dv_in = divisor;
		end else begin : g_next
			assign rq_in = rq_s[i-1];
			assign dv_in = dv_s[i-1];
		end

		// trial subtract of the divisor from remainder plus next dividend bit
		always_comb begin
			top  = rq_in[W+QW-1:QW-1];
			diff = top - {1'b0, dv_in};
			ge   = (top >= {1'b0, dv_in});
		end

		always_ff @(posedge clk) begin
			if (ge) begin
				rq_s[i] <= {diff[W-1:0], rq_in[QW-2:0], 1'b1};
			end else begin
				rq_s[i] <= {top[W-1:0], rq_in[QW-2:0], 1'b0};
			end
			dv_s[i] <= dv_in;
		end
	end

	assign quotient = rq_s[QW-1][QW-1:0];

endmodule

`default_nettype wire

// ===== rtl/rbsi_sel.sv =====
// rbsi_sel: signs and caps the six face times, picks latest entry and earliest exit, decides hit
// depends on rbsi_pkg; two register stages
`default_nettype none

module rbsi_sel #(
	parameter int QW = 49
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rbsi_pkg::slab_ctl_t              sc_i,
	input  logic [QW-1:0]                    quo_i [6],
	input  logic [rbsi_pkg::EPS_WIDTH-1:0]   eps_i,
	output rbsi_pkg::ctl_t                   ctl_o,
	output logic signed [QW:0]               time_o
);

	import rbsi_pkg::*;

	// face time magnitude cap (only reachable for wide coordinates)
	localparam logic [QW-1:0] QCAP = (QW > 63) ? QW'(64'h7FFF_FFFF_FFFF_FFFF) : {QW{1'b1}};

	logic [QW-1:0]      tc;
	logic signed [QW:0] ts [6];

	logic signed [QW:0] ent_t_s1 [3];
	logic signed [QW:0] ext_t_s1 [3];
	face_t              ent_f_s1 [3];
	face_t              ext_f_s1 [3];
	logic [2:0]         ok_s1;
	logic               rej_s1;
	logic               vld_s1;

	logic signed [QW:0] tin, tout, tsel, epsx;
	face_t              fin, fout, fsel;
	logic               vin, vout, hit_c;

	ctl_t               ctl_s2;
	logic signed [QW:0] time_s2;

	// signed, capped face times
	always_comb begin
		tc = '0;
		for (int f = 0; f < 6; f++) begin
			tc    = (quo_i[f] > QCAP) ? QCAP : quo_i[f];
			ts[f] = sc_i.neg[f] ? -$signed({1'b0, tc}) : $signed({1'b0, tc});
		end
	end

	// stage 1: entry and exit candidate of each axis
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= sc_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		rej_s1 <= sc_i.rej;
		ok_s1  <= ~sc_i.dzero;
		for (int a = 0; a < 3; a++) begin
			if (sc_i.dpos[a]) begin
				ent_t_s1[a] <= ts[2*a+1];
				ent_f_s1[a] <= FACE_MINUS[a];
				ext_t_s1[a] <= ts[2*a];
				ext_f_s1[a] <= FACE_PLUS[a];
			end else begin
				ent_t_s1[a] <= ts[2*a];
				ent_f_s1[a] <= FACE_PLUS[a];
				ext_t_s1[a] <= ts[2*a+1];
				ext_f_s1[a] <= FACE_MINUS[a];
			end
		end
	end

	// latest entry, earliest exit; lower face wins ties
	always_comb begin
		vin  = 1'b0;
		vout = 1'b0;
		tin  = '0;
		tout = '0;
		fin  = FACE_PX;
		fout = FACE_PX;
		epsx = $signed({{(QW+1-EPS_WIDTH){1'b0}}, eps_i});
		for (int a = 0; a < 3; a++) begin
			if (ok_s1[a]) begin
				if (!vin || ent_t_s1[a] > tin) begin
					tin = ent_t_s1[a];
					fin = ent_f_s1[a];
					vin = 1'b1;
				end
				if (!vout || ext_t_s1[a] < tout) begin
					tout = ext_t_s1[a];
					fout = ext_f_s1[a];
					vout = 1'b1;
				end
			end
		end
		hit_c = !rej_s1 && vin && vout && (tin < tout) && ((tin > epsx) || (tout > epsx));
		tsel  = (tin > epsx) ? tin : tout;
		fsel  = (tin > epsx) ? fin : fout;
	end

	// stage 2: hit decision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2.valid <= vld_s1;
			ctl_s2.hit   <= hit_c;
			ctl_s2.face  <= hit_c ? fsel : FACE_PX;
		end
	end

	always_ff @(posedge clk) begin
		time_s2 <= tsel;
	end

	assign ctl_o  = ctl_s2;
	assign time_o = time_s2;

endmodule

`default_nettype wire

// ===== rtl/rbsi_point.sv =====
// rbsi_point: hit point origin + direction * time with saturation, and the result register
// depends on rbsi_pkg; two register stages (split product, then sum and saturate)
`default_nettype none

module rbsi_point #(
	parameter int W  = 32,
	parameter int QW = 49
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rbsi_pkg::ctl_t        ctl_i,
	input  logic signed [QW:0]    time_i,
	input  logic [2:0][W-1:0]     p_i,
	input  logic [2:0][W-1:0]     d_i,
	output logic                  done,
	output logic                  hit,
	output logic signed [W-1:0]   hit_time,
	output logic signed [W-1:0]   hit_x,
	output logic signed [W-1:0]   hit_y,
	output logic signed [W-1:0]   hit_z,
	output rbsi_pkg::face_t       face
);

	import rbsi_pkg::*;

	localparam int LH  = (QW + 1) / 2;
	localparam int HH  = QW - LH;
	localparam int PLW = W + LH + 1;
	localparam int PHW = W + HH + 1;
	localparam int PW  = W + QW + 1;

	localparam logic [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};

	logic [QW-1:0]         tm;
	logic signed [PLW-1:0] plo_s1 [3];
	logic signed [PHW-1:0] phi_s1 [3];
	logic signed [W-1:0]   p_s1   [3];
	logic [W-1:0]          htime_s1;
	ctl_t                  ctl_s1;

	logic signed [PW-1:0]  full [3];
	logic signed [PW-1:0]  sum  [3];
	logic [W-1:0]          sat  [3];

	logic                  done_s2;
	logic                  hit_s2;
	logic [W-1:0]          htime_s2;
	logic [W-1:0]          pt_s2 [3];
	face_t                 face_s2;

	// time is positive whenever the item hits
	assign tm = time_i[QW-1:0];

	// stage 1: two partial products per axis, saturated hit time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			plo_s1[a] <= $signed(d_i[a]) * $signed({1'b0, tm[LH-1:0]});
			phi_s1[a] <= $signed(d_i[a]) * $signed({1'b0, tm[QW-1:LH]});
			p_s1[a]   <= p_i[a];
		end
		htime_s1 <= (|tm[QW-1:W-1]) ? W_MAX : tm[W-1:0];
	end

	// combine, floor to the fraction, add origin, saturate
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			full[a] = (PW'(phi_s1[a]) <<< LH) + PW'(plo_s1[a]);
			sum[a]  = (full[a] >>> FRAC_BITS) + PW'(p_s1[a]);
			if ((sum[a][PW-1:W-1] == '0) || (sum[a][PW-1:W-1] == '1)) begin
				sat[a] = sum[a][W-1:0];
			end else begin
				sat[a] = sum[a][PW-1] ? W_MIN : W_MAX;
			end
		end
	end

	// stage 2: result register, fields zero on a miss
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
			hit_s2  <= 1'b0;
		end else begin
			done_s2 <= ctl_s1.valid;
			hit_s2  <= ctl_s1.valid && ctl_s1.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.hit) begin
			htime_s2 <= htime_s1;
			face_s2  <= ctl_s1.face;
			for (int a = 0; a < 3; a++) begin
				pt_s2[a] <= sat[a];
			end
		end else begin
			htime_s2 <= '0;
			face_s2  <= FACE_PX;
			for (int a = 0; a < 3; a++) begin
				pt_s2[a] <= '0;
			end
		end
	end

	assign done     = done_s2;
	assign hit      = hit_s2;
	assign hit_time = htime_s2;
	assign hit_x    = pt_s2[0];
	assign hit_y    = pt_s2[1];
	assign hit_z    = pt_s2[2];
	assign face     = face_s2;

endmodule

`default_nettype wire

// ===== rtl/ray_unit_box_slab_intersect.sv =====
// ray_unit_box_slab_intersect: ray versus cube [-1,1]^3 by slabs, Q16.16 fixed point
// depends on rbsi_pkg, rbsi_div, rbsi_sel, rbsi_point
`default_nettype none

// One ray is taken at every clock edge where start is high; busy stays low, so a ray
// may follow in every cycle. Each ray gives exactly one result, shown on the result
// ports for one cycle with done high. A ray passes through one input stage, the six
// face dividers, which produce one quotient bit per pipeline stage (COORD_WIDTH + 17
// stages), two selection stages and two hit point stages. The receiver cannot hold
// results off.
// epsilon is written through cfg_we/cfg_data and should only change while no ray is in
// flight. On a miss hit is low and all other result fields read zero.
module ray_unit_box_slab_intersect #(
	parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [COORD_WIDTH-1:0]     origin_x,
	input  logic signed [COORD_WIDTH-1:0]     origin_y,
	input  logic signed [COORD_WIDTH-1:0]     origin_z,
	input  logic signed [COORD_WIDTH-1:0]     direction_x,
	input  logic signed [COORD_WIDTH-1:0]     direction_y,
	input  logic signed [COORD_WIDTH-1:0]     direction_z,
	input  logic                              cfg_we,
	input  logic [rbsi_pkg::EPS_WIDTH-1:0]    cfg_data,
	output logic                              done,
	output logic                              hit,
	output logic signed [COORD_WIDTH-1:0]     hit_time,
	output logic signed [COORD_WIDTH-1:0]     hit_x,
	output logic signed [COORD_WIDTH-1:0]     hit_y,
	output logic signed [COORD_WIDTH-1:0]     hit_z,
	output rbsi_pkg::face_t                   face
);

	import rbsi_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int QW  = W + FRAC_BITS + 1;
	localparam int LAT = QW + 5;

	localparam logic signed [W+1:0] Q_ONE = {{(W+1-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

	typedef struct packed {
		logic [2:0][W-1:0] p;
		logic [2:0][W-1:0] d;
	} pd_t;

	logic [EPS_WIDTH-1:0] eps_q;

	logic signed [W-1:0]   p_in [3];
	logic signed [W-1:0]   d_in [3];
	logic signed [W+1:0]   num  [6];
	logic signed [W+1:0]   epsn;
	slab_ctl_t             sc_c;

	slab_ctl_t             sc_s1;
	logic [W:0]            nmag_s1 [6];
	logic [W-1:0]          dmag_s1 [3];
	pd_t                   pd_s1;

	slab_ctl_t             sc_dl_s [QW];
	pd_t                   pd_dl_s [QW+2];

	logic [QW-1:0]         quo [6];
	ctl_t                  sel_ctl;
	logic signed [QW:0]    sel_time;

	assign busy = 1'b0;

	assign p_in[0] = origin_x;
	assign p_in[1] = origin_y;
	assign p_in[2] = origin_z;
	assign d_in[0] = direction_x;
	assign d_in[1] = direction_y;
	assign d_in[2] = direction_z;

	// epsilon register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_we) begin
			eps_q <= cfg_data;
		end
	end

	// plane distances, signs and the zero-direction outside test
	always_comb begin
		epsn  = $signed({{(W+2-EPS_WIDTH){1'b0}}, eps_q});
		sc_c  = '0;
		sc_c.valid = start;
		for (int a = 0; a < 3; a++) begin
			num[2*a]   = Q_ONE - (W+2)'(p_in[a]);
			num[2*a+1] = Q_ONE + (W+2)'(p_in[a]);
			sc_c.dzero[a]    = (d_in[a] == '0);
			sc_c.dpos[a]     = (d_in[a] != '0) && !d_in[a][W-1];
			sc_c.neg[2*a]    = num[2*a][W+1] ^ d_in[a][W-1];
			sc_c.neg[2*a+1]  = num[2*a+1][W+1] ^ sc_c.dpos[a];
			if (sc_c.dzero[a] && ((num[2*a] < epsn) || (num[2*a+1] < epsn))) begin
				sc_c.rej = 1'b1;
			end
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_s1 <= '0;
		end else begin
			sc_s1 <= sc_c;
		end
	end

	always_ff @(posedge clk) begin
		for (int f = 0; f < 6; f++) begin
			nmag_s1[f] <= num[f][W+1] ? (W+1)'(0) - num[f][W:0] : num[f][W:0];
		end
		for (int a = 0; a < 3; a++) begin
			dmag_s1[a] <= d_in[a][W-1] ? W'(0) - d_in[a] : d_in[a];
			pd_s1.p[a] <= p_in[a];
			pd_s1.d[a] <= d_in[a];
		end
	end

	// face dividers: (|num| << 16) / |d|
	for (genvar f = 0; f < 6; f++) begin : g_div
		rbsi_div #(
			.W  (W),
			.QW (QW)
		) u_div (
			.clk      (clk),
			.dividend ({nmag_s1[f], {FRAC_BITS{1'b0}}}),
			.divisor  (dmag_s1[f/2]),
			.quotient (quo[f])
		);
	end

	// flags and coordinates ride beside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QW; i++) begin
				sc_dl_s[i] <= '0;
			end
		end else begin
			sc_dl_s[0] <= sc_s1;
			for (int i = 1; i < QW; i++) begin
				sc_dl_s[i] <= sc_dl_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		pd_dl_s[0] <= pd_s1;
		for (int i = 1; i < QW + 2; i++) begin
			pd_dl_s[i] <= pd_dl_s[i-1];
		end
	end

	rbsi_sel #(
		.QW (QW)
	) u_sel (
		.clk    (clk),
		.arst_n (arst_n),
		.sc_i   (sc_dl_s[QW-1]),
		.quo_i  (quo),
		.eps_i  (eps_q),
		.ctl_o  (sel_ctl),
		.time_o (sel_time)
	);

	rbsi_point #(
		.W  (W),
		.QW (QW)
	) u_point (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_i    (sel_ctl),
		.time_i   (sel_time),
		.p_i      (pd_dl_s[QW+1].p),
		.d_i      (pd_dl_s[QW+1].d),
		.done     (done),
		.hit      (hit),
		.hit_time (hit_time),
		.hit_x    (hit_x),
		.hit_y    (hit_y),
		.hit_z    (hit_z),
		.face     (face)
	);

	// every taken item comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("item result missing at fixed latency");

	// a miss carries zero fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (hit_time == '0 && hit_x == '0 && hit_y == '0 &&
			hit_z == '0 && face == FACE_PX))
		else $error("miss with nonzero result fields");

	// a hit lies at positive time on a real face
	a_hit_sane: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> (hit_time > 0 && face <= FACE_NZ))
		else $error("hit with bad time or face");

endmodule

`default_nettype wire
